// ===== rtl/y86_execute_stage_alu_macros.svh =====
// Assertion macros for the execute stage.
`ifndef Y86_EXECUTE_STAGE_ALU_MACROS_SVH
`define Y86_EXECUTE_STAGE_ALU_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define Y86EX_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define Y86EX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/y86ex_pkg.sv =====
// Shared constants and types for the Y86-64 execute stage.
package y86ex_pkg;

  localparam int WORD_BITS = 64;
  localparam int DATA_BITS = 64;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  // instruction codes
  localparam logic [3:0] OP_HALT  = 4'd0;
  localparam logic [3:0] OP_NOP   = 4'd1;
  localparam logic [3:0] OP_RRMOV = 4'd2;
  localparam logic [3:0] OP_IRMOV = 4'd3;
  localparam logic [3:0] OP_RMMOV = 4'd4;
  localparam logic [3:0] OP_MRMOV = 4'd5;
  localparam logic [3:0] OP_ALU   = 4'd6;
  localparam logic [3:0] OP_JUMP  = 4'd7;
  localparam logic [3:0] OP_CALL  = 4'd8;
  localparam logic [3:0] OP_RET   = 4'd9;
  localparam logic [3:0] OP_PUSH  = 4'd10;
  localparam logic [3:0] OP_POP   = 4'd11;

  // ALU function codes
  localparam logic [3:0] FN_ADD = 4'd0;
  localparam logic [3:0] FN_SUB = 4'd1;
  localparam logic [3:0] FN_AND = 4'd2;
  localparam logic [3:0] FN_XOR = 4'd3;
  localparam logic [3:0] FN_MUL = 4'd4;
  localparam logic [3:0] FN_DIV = 4'd5;
  localparam logic [3:0] FN_MOD = 4'd6;

  // condition codes
  localparam logic [3:0] CC_ALWAYS = 4'd0;
  localparam logic [3:0] CC_LE     = 4'd1;
  localparam logic [3:0] CC_L      = 4'd2;
  localparam logic [3:0] CC_E      = 4'd3;
  localparam logic [3:0] CC_NE     = 4'd4;
  localparam logic [3:0] CC_GE     = 4'd5;
  localparam logic [3:0] CC_G      = 4'd6;

  // stage status
  localparam logic [1:0] STAT_AOK  = 2'd0;
  localparam logic [1:0] STAT_BUB  = 2'd1;
  localparam logic [1:0] STAT_HOLD = 2'd2;
  localparam logic [1:0] STAT_EXC  = 2'd3;

  localparam logic [3:0] REG_NONE = 4'hF;

  localparam logic [WORD_BITS-1:0] STACK_STEP = WORD_BITS'(8);

  typedef struct packed {
    logic zero;
    logic sign;
    logic ovf;
  } flags_t;

  function automatic logic [DATA_BITS-1:0] sext_word(input logic [WORD_BITS-1:0] x);
    return DATA_BITS'(signed'(x));
  endfunction

endpackage

// ===== rtl/y86_execute_stage_alu.sv =====
// Y86-64 execute stage: ALU, address adder, condition flags and branch decision.
//
//   channel | ports             | direction | word
//   --------+-------------------+-----------+-----------------------------------
//   in      | in_valid/in_stall | into      | decode-to-execute register
//   out     | out_valid/out_stall| out of   | execute-to-memory register
//
// Plain ops go from accept to S_FIN, then load the output register once it is free. MUL runs a
// shift-add loop of WORD_BITS steps plus a sign fix.
// DIV/MOD run a restoring divider, one quotient bit per cycle.
// The shared step adder in the iteration loop sets the worst-case pace.
// Reset (rst_n low, synchronous) clears the sequencer, out_valid and flags.
// in_stall is high from accept until the word is moved into the output
// register; a held output word delays that move but not the current iteration.
`include "y86_execute_stage_alu_macros.svh"

module y86_execute_stage_alu (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [3:0]  in_function_req,
  input  logic [1:0]  in_stage_status,
  input  logic [63:0] in_pc,
  input  logic [3:0]  in_dest_e,
  input  logic [3:0]  in_dest_m,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  input  logic signed [63:0] in_constant_c,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_pc,
  output logic [3:0]  out_operation,
  output logic [3:0]  out_function,
  output logic [1:0]  out_status,
  output logic [3:0]  out_dest_e,
  output logic [3:0]  out_dest_m,
  output logic signed [63:0] out_operand_a,
  output logic signed [63:0] out_alu_result,
  output logic        out_condition_true
);

  localparam int W  = y86ex_pkg::WORD_BITS;
  localparam int CB = y86ex_pkg::CNT_BITS;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;  // mul/div iteration
  localparam logic [1:0] S_MFIX = 2'd2;  // product sign fix
  localparam logic [1:0] S_FIN  = 2'd3;  // final adder, flags, output load

  logic [1:0]    state_r, state_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt;

  // latched instruction
  logic [3:0]   op_r, fn_r, de_r, dm_r;
  logic [1:0]   st_r;
  logic [63:0]  pc_r, a_raw_r;
  logic [W-1:0] a_r, b_r, c_r;
  logic         sa_r, sb_r;

  // iteration registers: acc holds {hi, lo} of product or {rem, dividend/quotient}
  logic [2*W-1:0] acc_r, acc_nxt;
  logic [W-1:0]   mag_r;

  y86ex_pkg::flags_t flags_r, flags_nxt;

  // output register
  logic         out_valid_r;
  logic [63:0]  out_pc_r, out_operand_a_r, out_alu_result_r;
  logic [3:0]   out_operation_r, out_function_r, out_dest_e_r, out_dest_m_r;
  logic [1:0]   out_status_r;
  logic         out_cond_r;

  // ---------------------------------------------------------------- accept
  logic         in_take;
  logic [3:0]   eop, ede, edm;
  logic [1:0]   est;
  logic [W-1:0] a_w, b_w, ma, mb;
  logic         is_alu, go_mul, go_div;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    eop = in_operation;
    ede = in_dest_e;
    edm = in_dest_m;
    est = in_stage_status;
    if (in_stage_status == y86ex_pkg::STAT_BUB) begin
      eop = y86ex_pkg::OP_NOP;
      ede = y86ex_pkg::REG_NONE;
      edm = y86ex_pkg::REG_NONE;
    end else if (in_stage_status == y86ex_pkg::STAT_HOLD) begin
      est = y86ex_pkg::STAT_AOK;
    end
    a_w    = in_operand_a[W-1:0];
    b_w    = in_operand_b[W-1:0];
    ma     = a_w[W-1] ? (~a_w + W'(1)) : a_w;
    mb     = b_w[W-1] ? (~b_w + W'(1)) : b_w;
    is_alu = (est != y86ex_pkg::STAT_EXC) && (eop == y86ex_pkg::OP_ALU);
    go_mul = is_alu && (in_function_req == y86ex_pkg::FN_MUL);
    go_div = is_alu && ((in_function_req == y86ex_pkg::FN_DIV) ||
                        (in_function_req == y86ex_pkg::FN_MOD)) && (a_w != '0);
  end

  // ---------------------------------------------------- shared step adder
  logic         step_mul, step_cin, step_ok;
  logic [W:0]   step_x, step_y;
  logic [W+1:0] step_sum;

  assign step_mul = (fn_r == y86ex_pkg::FN_MUL);

  always_comb begin
    if (step_mul) begin
      step_x   = {1'b0, acc_r[2*W-1:W]};
      step_y   = {1'b0, (acc_r[0] ? mag_r : '0)};
      step_cin = 1'b0;
    end else begin
      // trial subtract of the divisor from {rem, next dividend bit}
      step_x   = {acc_r[2*W-1:W], acc_r[W-1]};
      step_y   = ~{1'b0, mag_r};
      step_cin = 1'b1;
    end
    step_sum = {1'b0, step_x} + {1'b0, step_y} + (W+2)'(step_cin);
    step_ok  = step_sum[W+1];
  end

  // ---------------------------------------------------- final adder / result
  logic [W-1:0] fin_x, fin_y, fin_sum, quo, rem, res_w;
  logic         fin_cin, qneg, ovf, known, taken, lt;
  y86ex_pkg::flags_t flags_upd;

  assign quo  = acc_r[W-1:0];
  assign rem  = acc_r[2*W-1:W];
  assign qneg = sa_r ^ sb_r;

  always_comb begin
    fin_x   = b_r;
    fin_y   = a_r;
    fin_cin = 1'b0;
    unique case (op_r)
      y86ex_pkg::OP_ALU: begin
        unique case (fn_r)
          y86ex_pkg::FN_SUB: begin
            fin_y   = ~a_r;
            fin_cin = 1'b1;
          end
          y86ex_pkg::FN_DIV: begin
            fin_x   = '0;
            fin_y   = qneg ? ~quo : quo;
            fin_cin = qneg;
          end
          y86ex_pkg::FN_MOD: begin
            fin_x   = '0;
            fin_y   = sb_r ? ~rem : rem;
            fin_cin = sb_r;
          end
          default: ;
        endcase
      end
      y86ex_pkg::OP_RMMOV, y86ex_pkg::OP_MRMOV: fin_y = c_r;
      y86ex_pkg::OP_RET, y86ex_pkg::OP_POP:     fin_y = y86ex_pkg::STACK_STEP;
      y86ex_pkg::OP_CALL, y86ex_pkg::OP_PUSH: begin
        fin_y   = ~y86ex_pkg::STACK_STEP;
        fin_cin = 1'b1;
      end
      default: ;
    endcase
    fin_sum = fin_x + fin_y + W'(fin_cin);
  end

  always_comb begin
    res_w = '0;
    ovf   = 1'b0;
    known = 1'b1;
    unique case (op_r)
      y86ex_pkg::OP_ALU: begin
        unique case (fn_r)
          y86ex_pkg::FN_ADD: begin
            res_w = fin_sum;
            ovf   = (b_r[W-1] == a_r[W-1]) && (fin_sum[W-1] != b_r[W-1]);
          end
          y86ex_pkg::FN_SUB: begin
            res_w = fin_sum;
            ovf   = (b_r[W-1] != a_r[W-1]) && (fin_sum[W-1] != b_r[W-1]);
          end
          y86ex_pkg::FN_AND: res_w = b_r & a_r;
          y86ex_pkg::FN_XOR: res_w = b_r ^ a_r;
          y86ex_pkg::FN_MUL: begin
            res_w = acc_r[W-1:0];
            ovf   = (acc_r[2*W-1:W] != {W{acc_r[W-1]}});
          end
          y86ex_pkg::FN_DIV, y86ex_pkg::FN_MOD: begin
            // zero divisor gives the dividend back
            res_w = (a_r == '0) ? b_r : fin_sum;
            ovf   = (a_r == '0);
          end
          default: known = 1'b0;
        endcase
      end
      y86ex_pkg::OP_IRMOV: res_w = c_r;
      y86ex_pkg::OP_RRMOV: res_w = a_r;
      y86ex_pkg::OP_RMMOV, y86ex_pkg::OP_MRMOV, y86ex_pkg::OP_CALL,
      y86ex_pkg::OP_RET, y86ex_pkg::OP_PUSH, y86ex_pkg::OP_POP: res_w = fin_sum;
      default: res_w = '0;
    endcase
    if (st_r == y86ex_pkg::STAT_EXC) begin
      res_w = '0;
    end

    flags_upd.zero = (res_w == '0);
    flags_upd.sign = res_w[W-1];
    flags_upd.ovf  = known ? ovf : flags_r.ovf;

    // branch / cmov decision from the kept flags
    lt    = flags_r.sign ^ flags_r.ovf;
    taken = 1'b1;
    if ((op_r == y86ex_pkg::OP_RRMOV) || (op_r == y86ex_pkg::OP_JUMP)) begin
      unique case (fn_r)
        y86ex_pkg::CC_ALWAYS: taken = 1'b1;
        y86ex_pkg::CC_LE:     taken = lt || flags_r.zero;
        y86ex_pkg::CC_L:      taken = lt;
        y86ex_pkg::CC_E:      taken = flags_r.zero;
        y86ex_pkg::CC_NE:     taken = !flags_r.zero;
        y86ex_pkg::CC_GE:     taken = !lt;
        y86ex_pkg::CC_G:      taken = !lt && !flags_r.zero;
        default:              taken = 1'b0;
      endcase
    end
    if (st_r == y86ex_pkg::STAT_EXC) begin
      taken = 1'b0;
    end
  end

  // ---------------------------------------------------------- sequencer
  logic out_free, fin_load;

  assign out_free = !out_valid_r || !out_stall;
  assign fin_load = (state_r == S_FIN) && out_free;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    flags_nxt = flags_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_take) begin
          acc_nxt   = go_mul ? {{W{1'b0}}, ma} : {{W{1'b0}}, mb};
          state_nxt = (go_mul || go_div) ? S_RUN : S_FIN;
        end
      end
      S_RUN: begin
        if (step_mul) begin
          acc_nxt = {step_sum[W:0], acc_r[W-1:1]};
        end else begin
          acc_nxt = {(step_ok ? step_sum[W-1:0] : step_x[W-1:0]), acc_r[W-2:0], step_ok};
        end
        cnt_nxt = cnt_r + CB'(1);
        if (cnt_r == CB'(W-1)) begin
          state_nxt = step_mul ? S_MFIX : S_FIN;
        end
      end
      S_MFIX: begin
        if (qneg) begin
          acc_nxt = ~acc_r + (2*W)'(1);
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          if ((st_r != y86ex_pkg::STAT_EXC) && (op_r == y86ex_pkg::OP_ALU)) begin
            flags_nxt = flags_upd;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      flags_r <= flags_nxt;
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (in_take) begin
      op_r    <= eop;
      fn_r    <= in_function_req;
      st_r    <= est;
      de_r    <= ede;
      dm_r    <= edm;
      pc_r    <= in_pc;
      a_raw_r <= in_operand_a;
      a_r     <= a_w;
      b_r     <= b_w;
      c_r     <= in_constant_c[W-1:0];
      sa_r    <= a_w[W-1];
      sb_r    <= b_w[W-1];
      mag_r   <= go_mul ? mb : ma;
    end
    if (fin_load) begin
      out_pc_r         <= pc_r;
      out_operation_r  <= op_r;
      out_function_r   <= fn_r;
      out_status_r     <= st_r;
      out_dest_e_r     <= de_r;
      out_dest_m_r     <= dm_r;
      out_operand_a_r  <= a_raw_r;
      out_alu_result_r <= y86ex_pkg::sext_word(res_w);
      out_cond_r       <= taken;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pc             = out_pc_r;
  assign out_operation      = out_operation_r;
  assign out_function       = out_function_r;
  assign out_status         = out_status_r;
  assign out_dest_e         = out_dest_e_r;
  assign out_dest_m         = out_dest_m_r;
  assign out_operand_a      = out_operand_a_r;
  assign out_alu_result     = out_alu_result_r;
  assign out_condition_true = out_cond_r;

  // ---------------------------------------------------------- assertions
  logic out_bubble, bubble_clean;

  assign out_bubble   = out_valid && (out_status == y86ex_pkg::STAT_BUB);
  assign bubble_clean = (out_dest_e == y86ex_pkg::REG_NONE) &&
                        (out_dest_m == y86ex_pkg::REG_NONE) && (out_alu_result == '0);

  `Y86EX_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, in_stall, "no busy after accept")
  `Y86EX_ASSERT_NOW(a_load_from_fin, clk, rst_n, $rose(out_valid), $past(state_r == S_FIN), "early load")
  `Y86EX_ASSERT_NEXT(a_flags_hold, clk, rst_n, state_r != S_FIN, $stable(flags_r), "flags moved")
  `Y86EX_ASSERT_NOW(a_bubble_nop, clk, rst_n, out_bubble, bubble_clean, "bubble word not a clean nop")

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the Y86-64 execute stage: random and directed words with checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] WORD_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WORD_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int RANDOM_WORDS      = 1415;
  localparam int SETTLE_CYCLES     = 100;  // longer than the slowest mul/div path
  localparam int LONG_HOLD_AT      = 300;  // result count that triggers the long sink hold
  localparam int LONG_HOLD_CYCLES  = 400;

  // decode-to-execute word as offered on the input channel
  typedef struct {
    logic [3:0]  op;
    logic [3:0]  fn;
    logic [1:0]  st;
    logic [63:0] pc;
    logic [3:0]  de;
    logic [3:0]  dm;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    bit          wait_drain;  // hold this word back until all results are in
  } dx_word_t;

  // execute-to-memory word as expected on the result channel
  typedef struct {
    logic [63:0] pc;
    logic [3:0]  op;
    logic [3:0]  fn;
    logic [1:0]  st;
    logic [3:0]  de;
    logic [3:0]  dm;
    logic [63:0] opa;
    logic [63:0] res;
    logic        taken;
  } em_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_operation = '0;
  logic [3:0]  in_function_req = '0;
  logic [1:0]  in_stage_status = '0;
  logic [63:0] in_pc = '0;
  logic [3:0]  in_dest_e = '0;
  logic [3:0]  in_dest_m = '0;
  logic [63:0] in_operand_a = '0;
  logic [63:0] in_operand_b = '0;
  logic [63:0] in_constant_c = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_pc;
  logic [3:0]  out_operation;
  logic [3:0]  out_function;
  logic [1:0]  out_status;
  logic [3:0]  out_dest_e;
  logic [3:0]  out_dest_m;
  logic [63:0] out_operand_a;
  logic [63:0] out_alu_result;
  logic        out_condition_true;

  dx_word_t dx_pending[$];    // words still to be offered
  em_word_t em_expected[$];   // predicted results, oldest first
  y86ex_pkg::flags_t cc_flags = '0;  // predicted zero/sign/overflow flags
  int       mismatches = 0;
  int       results_seen = 0;
  int       words_accepted = 0;

  y86_execute_stage_alu u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_function_req   (in_function_req),
    .in_stage_status   (in_stage_status),
    .in_pc             (in_pc),
    .in_dest_e         (in_dest_e),
    .in_dest_m         (in_dest_m),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .in_constant_c     (in_constant_c),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pc            (out_pc),
    .out_operation     (out_operation),
    .out_function      (out_function),
    .out_status        (out_status),
    .out_dest_e        (out_dest_e),
    .out_dest_m        (out_dest_m),
    .out_operand_a     (out_operand_a),
    .out_alu_result    (out_alu_result),
    .out_condition_true(out_condition_true)
  );

  always #10 clk = ~clk;

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Execute one accepted word against the predicted flags and return the
  // register the stage should hand to memory. Only ALU ops touch the flags.
  function automatic em_word_t execute_word(input dx_word_t w);
    em_word_t r;
    logic [63:0] a, b, res, ua, ub, q;
    logic signed [127:0] sa, sb, prod;
    logic ovf, known, lt;
    r.pc = w.pc;
    r.op = w.op;
    r.fn = w.fn;
    r.st = w.st;
    r.de = w.de;
    r.dm = w.dm;
    r.opa = w.a;
    r.taken = 1'b1;
    a = w.a;
    b = w.b;
    res = '0;
    if (w.st == y86ex_pkg::STAT_EXC) begin
      // exception: everything passes through, no result, flags untouched
      r.taken = 1'b0;
    end else begin
      if (w.st == y86ex_pkg::STAT_BUB) begin
        r.op = y86ex_pkg::OP_NOP;
        r.de = y86ex_pkg::REG_NONE;
        r.dm = y86ex_pkg::REG_NONE;
      end else if (w.st == y86ex_pkg::STAT_HOLD) begin
        r.st = y86ex_pkg::STAT_AOK;
      end
      case (r.op)
        y86ex_pkg::OP_ALU: begin
          ovf = 1'b0;
          known = 1'b1;
          case (w.fn)
            y86ex_pkg::FN_ADD: begin
              res = b + a;
              ovf = (b[63] == a[63]) && (res[63] != b[63]);
            end
            y86ex_pkg::FN_SUB: begin
              res = b - a;
              ovf = (b[63] != a[63]) && (res[63] != b[63]);
            end
            y86ex_pkg::FN_AND: res = b & a;
            y86ex_pkg::FN_XOR: res = b ^ a;
            y86ex_pkg::FN_MUL: begin
              // full signed product; overflow when the top half is not
              // the sign extension of the low word
              sa = $signed(b);
              sb = $signed(a);
              prod = sa * sb;
              res = prod[63:0];
              ovf = prod[127:64] != {64{prod[63]}};
            end
            y86ex_pkg::FN_DIV, y86ex_pkg::FN_MOD: begin
              if (a == '0) begin
                // zero divisor returns the dividend
                res = b;
                ovf = 1'b1;
              end else begin
                // magnitudes fit in 64 unsigned bits, so MIN / -1 wraps
                ua = a[63] ? 64'd0 - a : a;
                ub = b[63] ? 64'd0 - b : b;
                if (w.fn == y86ex_pkg::FN_DIV) begin
                  q = ub / ua;
                  res = (a[63] != b[63]) ? 64'd0 - q : q;
                end else begin
                  q = ub % ua;
                  res = b[63] ? 64'd0 - q : q;
                end
              end
            end
            default: begin
              // unknown function: zero result, overflow flag kept
              res = '0;
              known = 1'b0;
            end
          endcase
          if (known) cc_flags.ovf = ovf;
          cc_flags.zero = (res == '0);
          cc_flags.sign = res[63];
        end
        y86ex_pkg::OP_IRMOV: res = w.c;
        y86ex_pkg::OP_RET, y86ex_pkg::OP_POP: res = b + y86ex_pkg::STACK_STEP;
        y86ex_pkg::OP_CALL, y86ex_pkg::OP_PUSH: res = b - y86ex_pkg::STACK_STEP;
        y86ex_pkg::OP_RMMOV, y86ex_pkg::OP_MRMOV: res = b + w.c;
        y86ex_pkg::OP_RRMOV: res = a;
        default: res = '0;
      endcase
      if (r.op == y86ex_pkg::OP_RRMOV || r.op == y86ex_pkg::OP_JUMP) begin
        lt = cc_flags.sign ^ cc_flags.ovf;
        case (w.fn)
          y86ex_pkg::CC_ALWAYS: r.taken = 1'b1;
          y86ex_pkg::CC_LE:     r.taken = lt | cc_flags.zero;
          y86ex_pkg::CC_L:      r.taken = lt;
          y86ex_pkg::CC_E:      r.taken = cc_flags.zero;
          y86ex_pkg::CC_NE:     r.taken = ~cc_flags.zero;
          y86ex_pkg::CC_GE:     r.taken = ~lt;
          y86ex_pkg::CC_G:      r.taken = ~lt & ~cc_flags.zero;
          default:              r.taken = 1'b0;
        endcase
      end
    end
    r.res = res;
    return r;
  endfunction

  // Operand mix: extremes and small values often, so that carries,
  // overflow and exact division all show up.
  function automatic logic [63:0] pick_operand();
    int small_val;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    small_val = int'($urandom_range(200)) - 100;
    case ($urandom_range(9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return ALL_ONES;
      4: return 64'd1;
      5, 6: return 64'(small_val);
      7: return raw >> $urandom_range(63);
      default: return raw;
    endcase
  endfunction

  function automatic dx_word_t make_word(input logic [3:0] op, input logic [3:0] fn,
                                         input logic [1:0] st, input logic [63:0] a,
                                         input logic [63:0] b, input logic [63:0] c);
    dx_word_t w;
    w.op = op;
    w.fn = fn;
    w.st = st;
    w.pc = {$urandom, $urandom};
    w.de = 4'($urandom);
    w.dm = 4'($urandom);
    w.a = a;
    w.b = b;
    w.c = c;
    w.wait_drain = 1'b0;
    return w;
  endfunction

  // Random word: ALU ops and conditional moves/jumps dominate, with a tail
  // of unknown codes and non-regular status.
  function automatic dx_word_t random_word();
    logic [3:0] op, fn;
    logic [1:0] st;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 40) op = y86ex_pkg::OP_ALU;
    else if (roll < 55) op = y86ex_pkg::OP_RRMOV;
    else if (roll < 67) op = y86ex_pkg::OP_JUMP;
    else if (roll < 92) op = 4'($urandom_range(11));
    else op = 4'($urandom_range(15, 12));
    fn = ($urandom_range(99) < 85) ? 4'($urandom_range(6)) : 4'($urandom_range(15, 7));
    roll = $urandom_range(99);
    st = (roll < 70) ? y86ex_pkg::STAT_AOK : (roll < 82) ? y86ex_pkg::STAT_HOLD :
         (roll < 91) ? y86ex_pkg::STAT_BUB : y86ex_pkg::STAT_EXC;
    return make_word(op, fn, st, pick_operand(), pick_operand(), pick_operand());
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_length();
    if ($urandom_range(99) < 92) return $urandom_range(4, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d %s: expected %h, got %h", results_seen, name, want, got);
    end
  endtask

  // Driver: the word is predicted when it is accepted, then the next one is
  // offered after a random gap. Payload holds while stalled.
  int unsigned src_gap = 0;
  dx_word_t    src_word;

  always @(posedge clk) begin : drive_proc
    bit offer;
    bit quiet;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      // every sixth block of 128 words goes back to back
      quiet = ((words_accepted / 128) % 6) == 5;
      if (in_valid && !in_stall) begin
        em_expected.push_back(execute_word(src_word));
        words_accepted++;
        offer = 1'b0;
        src_gap = (quiet || $urandom_range(2) != 0) ? 0 : idle_length();
      end
      if (!offer) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (dx_pending.size() > 0 &&
                     !(dx_pending[0].wait_drain && em_expected.size() > 0)) begin
          src_word = dx_pending.pop_front();
          in_operation    <= src_word.op;
          in_function_req <= src_word.fn;
          in_stage_status <= src_word.st;
          in_pc           <= src_word.pc;
          in_dest_e       <= src_word.de;
          in_dest_m       <= src_word.dm;
          in_operand_a    <= src_word.a;
          in_operand_b    <= src_word.b;
          in_constant_c   <= src_word.c;
          offer = 1'b1;
        end
      end
      in_valid <= offer;
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // drives out_stall. One long hold, counted here, backs the stage up.
  int unsigned sink_stall = 0;
  int unsigned sink_hold = 0;
  int unsigned sink_cycles = 0;

  always @(posedge clk) begin : sink_proc
    em_word_t want;
    bit stall_next;
    bit quiet;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      sink_cycles++;
      quiet = ((sink_cycles / 1500) % 5) == 4;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (em_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing expected", results_seen);
        end else begin
          want = em_expected.pop_front();
          compare_field("pc", want.pc, out_pc);
          compare_field("operation", 64'(want.op), 64'(out_operation));
          compare_field("function", 64'(want.fn), 64'(out_function));
          compare_field("status", 64'(want.st), 64'(out_status));
          compare_field("dest_e", 64'(want.de), 64'(out_dest_e));
          compare_field("dest_m", 64'(want.dm), 64'(out_dest_m));
          compare_field("operand_a", want.opa, out_operand_a);
          compare_field("alu_result", want.res, out_alu_result);
          compare_field("condition_true", 64'(want.taken), 64'(out_condition_true));
        end
        if (results_seen == LONG_HOLD_AT) sink_hold = LONG_HOLD_CYCLES;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        stall_next = 1'b1;
      end else if (sink_stall > 0) begin
        sink_stall--;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
        if (!quiet && $urandom_range(4) == 0) sink_stall = idle_length();
      end
      out_stall <= stall_next;
    end
  end

  // Stimulus: directed corner cases first, then the random body.
  initial begin
    int n_directed;
    // arithmetic corners
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_ADD, y86ex_pkg::STAT_AOK,
                                   64'd1, WORD_MAX, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_SUB, y86ex_pkg::STAT_HOLD,
                                   64'd1, WORD_MIN, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_AND, y86ex_pkg::STAT_AOK,
                                   ALL_ONES, WORD_MIN, ALL_ONES));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_XOR, y86ex_pkg::STAT_AOK,
                                   ALL_ONES, ALL_ONES, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_MUL, y86ex_pkg::STAT_AOK,
                                   64'd2, WORD_MAX, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_MUL, y86ex_pkg::STAT_AOK,
                                   ALL_ONES, WORD_MIN, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_MUL, y86ex_pkg::STAT_AOK,
                                   64'(-3), 64'd7, '0));
    // zero divisor, most-negative by minus one, and minus seven by two
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_DIV, y86ex_pkg::STAT_AOK,
                                   '0, 64'(-5), '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_MOD, y86ex_pkg::STAT_AOK,
                                   '0, WORD_MAX, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_DIV, y86ex_pkg::STAT_AOK,
                                   ALL_ONES, WORD_MIN, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_MOD, y86ex_pkg::STAT_AOK,
                                   ALL_ONES, WORD_MIN, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_DIV, y86ex_pkg::STAT_HOLD,
                                   64'd2, 64'(-7), '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_MOD, y86ex_pkg::STAT_AOK,
                                   64'd2, 64'(-7), '0));
    // unknown ALU function, then an exception that must not move the flags
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, 4'hF, y86ex_pkg::STAT_AOK,
                                   WORD_MAX, WORD_MAX, '0));
    dx_pending.push_back(make_word(y86ex_pkg::OP_ALU, y86ex_pkg::FN_ADD, y86ex_pkg::STAT_EXC,
                                   64'd1, WORD_MAX, '0));
    // every condition once, alternating between cmov and jump, plus an unknown one and a bubble
    for (int k = 0; k <= 6; k++)
      dx_pending.push_back(make_word((k % 2) ? y86ex_pkg::OP_JUMP : y86ex_pkg::OP_RRMOV,
                                     4'(k), y86ex_pkg::STAT_AOK,
                                     pick_operand(), pick_operand(), pick_operand()));
    dx_pending.push_back(make_word(y86ex_pkg::OP_JUMP, 4'd9, y86ex_pkg::STAT_AOK,
                                   '0, '0, ALL_ONES));
    dx_pending.push_back(make_word(y86ex_pkg::OP_RRMOV, y86ex_pkg::CC_ALWAYS,
                                   y86ex_pkg::STAT_BUB, ALL_ONES, '0, '0));
    // remaining operations, unknown codes included
    for (int k = 0; k < 16; k++)
      if (k != y86ex_pkg::OP_ALU && k != y86ex_pkg::OP_RRMOV && k != y86ex_pkg::OP_JUMP)
        dx_pending.push_back(make_word(4'(k), 4'($urandom), y86ex_pkg::STAT_AOK,
                                       pick_operand(), pick_operand(), pick_operand()));
    n_directed = dx_pending.size();
    for (int n = 0; n < RANDOM_WORDS; n++) dx_pending.push_back(random_word());
    // sender waits for a full drain at the start of the random body and after 800 random words
    dx_pending[n_directed].wait_drain = 1'b1;
    dx_pending[n_directed + 800].wait_drain = 1'b1;

    // wait for all words to go in and all results to come out
    @(negedge clk);
    while (!rst_n || dx_pending.size() > 0 || in_valid || em_expected.size() > 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0 && em_expected.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
